@@ design/triangle_edge_rasterizer_top_assert.svh @@
// Assertion macros for the triangle edge rasterizer checker.
// Included by ter_checker.sv; holds nothing but macro definitions.
`ifndef TRIANGLE_EDGE_RASTERIZER_TOP_ASSERT_SVH
`define TRIANGLE_EDGE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define TER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ter_pkg.sv @@
// Shared types and constants for the triangle edge rasterizer.
// No dependencies; used by ter_setup, the top level and the checker.
`default_nettype none

package ter_pkg;

    // Field widths
    localparam int VERT_W  = 13;
    localparam int DIFF_W  = VERT_W + 1;
    localparam int ORI_W   = 2 * DIFF_W + 1;
    localparam int RGBA_W  = 32;
    localparam int CFG_W   = 12;

    // Config port
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    localparam int MAX_DIM_DEF = 2048;

    localparam logic [CFG_W-1:0] IMG_SIZE_RST = 12'd256;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [VERT_W-1:0] x;
        logic signed [VERT_W-1:0] y;
    } t_vert;

    typedef struct packed {
        t_vert a;
        t_vert b;
        t_vert c;
    } t_tri;

endpackage

`default_nettype wire

@@ design/triangle_edge_rasterizer_top.sv @@
// Triangle rasterizer by edge functions: input capture, setup pipeline,
// raster scan state and result register. Uses ter_pkg and ter_setup.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): a load item (command 0) brings
//   three vertices and a colour and gives no result; a step item (command 1)
//   gives one result, the next pixel of the row-major scan over the clamped
//   bounding box, or an idle result when no triangle is active.
//   Output channel (o_out_valid / i_out_stall) carries one result per step.
//   Throughput is one item per clock while o_in_stall is low. An item
//   passes an input register, two setup stages and the result register.
//   Edge functions advance by adds as the scan moves; only the load runs
//   multipliers, in the setup stages. When the receiver stalls the result
//   holds; items keep entering until the pipeline is full, then o_in_stall
//   rises.
//   Reset empties the pipeline, drops any active triangle and sets both image
//   sizes to 256. Image size registers sit at APB byte addresses 0 and 4; the
//   user must write them only while the block is idle; it does not enforce this.
`default_nettype none

module triangle_edge_rasterizer_top #(
    parameter int MAX_DIM = ter_pkg::MAX_DIM_DEF,
    localparam int CW = $clog2(MAX_DIM)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ter_pkg::APB_AW-1:0]         paddr,
    input  wire logic [ter_pkg::APB_DW-1:0]         pwdata,
    output logic [ter_pkg::APB_DW-1:0]              prdata,
    output logic                                    pready,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_command,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_a_x,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_a_y,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_b_x,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_b_y,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_c_x,
    input  wire logic signed [ter_pkg::VERT_W-1:0]  i_vert_c_y,
    input  wire logic [ter_pkg::RGBA_W-1:0]         i_fill_rgba,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [CW-1:0]                           o_pixel_x,
    output logic [CW-1:0]                           o_pixel_y,
    output logic                                    o_covered,
    output logic [ter_pkg::RGBA_W-1:0]              o_pixel_rgba,
    output logic                                    o_last_pixel,
    output logic                                    o_idle
);

    localparam int DW  = ((CW > ter_pkg::VERT_W - 1) ? CW : ter_pkg::VERT_W - 1) + 2;
    localparam int PW  = ter_pkg::DIFF_W + DW;
    localparam int EW  = PW + 1;
    localparam int SW  = ((ter_pkg::CFG_W > CW + 1) ? ter_pkg::CFG_W : CW + 1) + 1;
    localparam logic [SW-1:0] MAX_DIM_S = SW'(MAX_DIM);

    // ---------------- configuration registers ----------------
    logic [ter_pkg::CFG_W-1:0] r_img_w, r_img_h;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= ter_pkg::IMG_SIZE_RST;
            r_img_h <= ter_pkg::IMG_SIZE_RST;
        end else if (cfg_wr) begin
            case (paddr[ter_pkg::REG_SEL_BIT])
                ter_pkg::REG_IMAGE_WIDTH:  r_img_w <= pwdata[ter_pkg::CFG_W-1:0];
                ter_pkg::REG_IMAGE_HEIGHT: r_img_h <= pwdata[ter_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ter_pkg::REG_SEL_BIT])
            ter_pkg::REG_IMAGE_WIDTH:  prdata = ter_pkg::APB_DW'(r_img_w);
            ter_pkg::REG_IMAGE_HEIGHT: prdata = ter_pkg::APB_DW'(r_img_h);
            default:                   prdata = '0;
        endcase
    end

    // Saturated image size minus one, taken with the item
    logic [SW-1:0]         w_sat, h_sat;
    logic signed [CW:0]    n_wm1, n_hm1;

    always_comb begin
        w_sat = (SW'(r_img_w) > MAX_DIM_S) ? MAX_DIM_S : SW'(r_img_w);
        h_sat = (SW'(r_img_h) > MAX_DIM_S) ? MAX_DIM_S : SW'(r_img_h);
        n_wm1 = (CW + 1)'(w_sat - 1'b1);
        n_hm1 = (CW + 1)'(h_sat - 1'b1);
    end

    // ---------------- pipeline control ----------------
    logic r_p1_v, r_p2_v, r_p3_v;
    logic r_p1_cmd, r_p2_cmd, r_p3_cmd;
    logic r_out_v;
    logic en1, en2, en3, en_out;

    assign en_out     = !r_out_v || !i_out_stall;
    assign en3        = !r_p3_v || (r_p3_cmd == ter_pkg::CMD_LOAD) || en_out;
    assign en2        = !r_p2_v || en3;
    assign en1        = !r_p1_v || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            if (en1) r_p1_v <= i_in_valid;
            if (en2) r_p2_v <= r_p1_v;
            if (en3) r_p3_v <= r_p2_v;
        end
    end

    // Input register
    ter_pkg::t_tri              r_p1_tri;
    logic [ter_pkg::RGBA_W-1:0] r_p1_rgba;
    logic signed [CW:0]         r_p1_wm1, r_p1_hm1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p1_cmd   <= i_command;
            r_p1_tri   <= '{a: '{x: i_vert_a_x, y: i_vert_a_y},
                            b: '{x: i_vert_b_x, y: i_vert_b_y},
                            c: '{x: i_vert_c_x, y: i_vert_c_y}};
            r_p1_rgba  <= i_fill_rgba;
            r_p1_wm1   <= n_wm1;
            r_p1_hm1   <= n_hm1;
        end
        if (en2) r_p2_cmd <= r_p1_cmd;
        if (en3) r_p3_cmd <= r_p2_cmd;
    end

    // ---------------- setup stages ----------------
    logic signed [2*ter_pkg::DIFF_W-1:0] s_ori_p, s_ori_n;
    logic signed [PW-1:0]                s_prod_a [3];
    logic signed [PW-1:0]                s_prod_b [3];
    logic signed [ter_pkg::DIFF_W-1:0]   s_coef_a [3];
    logic signed [ter_pkg::DIFF_W-1:0]   s_coef_b [3];
    logic [CW-1:0]                       s_lo_x, s_lo_y, s_hi_x, s_hi_y;
    logic                                s_empty;
    logic [ter_pkg::RGBA_W-1:0]          s_rgba;

    ter_setup #(
        .MAX_DIM (MAX_DIM)
    ) u_setup (
        .i_clk    (i_clk),
        .i_en2    (en2),
        .i_en3    (en3),
        .i_tri    (r_p1_tri),
        .i_rgba   (r_p1_rgba),
        .i_wm1    (r_p1_wm1),
        .i_hm1    (r_p1_hm1),
        .o_ori_p  (s_ori_p),
        .o_ori_n  (s_ori_n),
        .o_prod_a (s_prod_a),
        .o_prod_b (s_prod_b),
        .o_coef_a (s_coef_a),
        .o_coef_b (s_coef_b),
        .o_lo_x   (s_lo_x),
        .o_lo_y   (s_lo_y),
        .o_hi_x   (s_hi_x),
        .o_hi_y   (s_hi_y),
        .o_empty  (s_empty),
        .o_rgba   (s_rgba)
    );

    // ---------------- scan state ----------------
    logic                               r_active, n_active;
    logic                               r_wind, n_wind;
    logic [CW-1:0]                      r_scan_x, n_scan_x, r_scan_y, n_scan_y;
    logic [CW-1:0]                      r_min_x, n_min_x, r_max_x, n_max_x;
    logic [CW-1:0]                      r_max_y, n_max_y;
    logic [ter_pkg::RGBA_W-1:0]         r_rgba, n_rgba;
    logic signed [EW-1:0]               r_e [3];
    logic signed [EW-1:0]               n_e [3];
    logic signed [EW-1:0]               r_er [3];
    logic signed [EW-1:0]               n_er [3];
    logic signed [ter_pkg::DIFF_W-1:0]  r_ca [3];
    logic signed [ter_pkg::DIFF_W-1:0]  n_ca [3];
    logic signed [ter_pkg::DIFF_W-1:0]  r_cb [3];
    logic signed [ter_pkg::DIFF_W-1:0]  n_cb [3];

    // Result next values
    logic [CW-1:0]              n_out_x, n_out_y;
    logic                       n_out_cov, n_out_last, n_out_idle;
    logic [ter_pkg::RGBA_W-1:0] n_out_rgba;

    logic signed [ter_pkg::ORI_W-1:0] ori;
    logic                             all_ge, all_le, at_row_end, at_last;

    always_comb begin
        n_active  = r_active;
        n_wind    = r_wind;
        n_scan_x  = r_scan_x;
        n_scan_y  = r_scan_y;
        n_min_x   = r_min_x;
        n_max_x   = r_max_x;
        n_max_y   = r_max_y;
        n_rgba    = r_rgba;
        for (int k = 0; k < 3; k++) begin
            n_e[k]  = r_e[k];
            n_er[k] = r_er[k];
            n_ca[k] = r_ca[k];
            n_cb[k] = r_cb[k];
        end
        n_out_x    = '0;
        n_out_y    = '0;
        n_out_cov  = 1'b0;
        n_out_rgba = '0;
        n_out_last = 1'b0;
        n_out_idle = 1'b0;

        ori = ter_pkg::ORI_W'(s_ori_p) - ter_pkg::ORI_W'(s_ori_n);

        // coverage: all edges >= 0 or all <= 0, by winding
        all_ge = 1'b1;
        all_le = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (r_e[k][EW-1]) all_ge = 1'b0;
            if (!r_e[k][EW-1] && (r_e[k] != '0)) all_le = 1'b0;
        end
        at_row_end = (r_scan_x == r_max_x);
        at_last    = at_row_end && (r_scan_y == r_max_y);

        if (r_p3_v && en3) begin
            if (r_p3_cmd == ter_pkg::CMD_LOAD) begin
                // new triangle replaces whatever was in progress
                n_wind   = !ori[ter_pkg::ORI_W-1] && (ori != '0);
                n_active = (ori != '0) && !s_empty;
                n_scan_x = s_lo_x;
                n_scan_y = s_lo_y;
                n_min_x  = s_lo_x;
                n_max_x  = s_hi_x;
                n_max_y  = s_hi_y;
                n_rgba   = s_rgba;
                for (int k = 0; k < 3; k++) begin
                    n_e[k]  = EW'(s_prod_a[k]) - EW'(s_prod_b[k]);
                    n_er[k] = EW'(s_prod_a[k]) - EW'(s_prod_b[k]);
                    n_ca[k] = s_coef_a[k];
                    n_cb[k] = s_coef_b[k];
                end
            end else if (!r_active) begin
                n_out_idle = 1'b1;
            end else begin
                n_out_x    = r_scan_x;
                n_out_y    = r_scan_y;
                n_out_cov  = r_wind ? all_ge : all_le;
                n_out_rgba = r_rgba;
                n_out_last = at_last;
                if (at_last) begin
                    n_active = 1'b0;
                end else if (at_row_end) begin
                    // next row: step row-start values by +A
                    n_scan_x = r_min_x;
                    n_scan_y = r_scan_y + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        n_er[k] = r_er[k] + EW'(r_ca[k]);
                        n_e[k]  = r_er[k] + EW'(r_ca[k]);
                    end
                end else begin
                    // next pixel in the row: step by -B
                    n_scan_x = r_scan_x + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        n_e[k] = r_e[k] - EW'(r_cb[k]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wind   <= n_wind;
        r_scan_x <= n_scan_x;
        r_scan_y <= n_scan_y;
        r_min_x  <= n_min_x;
        r_max_x  <= n_max_x;
        r_max_y  <= n_max_y;
        r_rgba   <= n_rgba;
        for (int k = 0; k < 3; k++) begin
            r_e[k]  <= n_e[k];
            r_er[k] <= n_er[k];
            r_ca[k] <= n_ca[k];
            r_cb[k] <= n_cb[k];
        end
    end

    // ---------------- result register ----------------
    logic [CW-1:0]              r_out_x, r_out_y;
    logic                       r_out_cov, r_out_last, r_out_idle;
    logic [ter_pkg::RGBA_W-1:0] r_out_rgba;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en_out) begin
            r_out_v <= r_p3_v && (r_p3_cmd == ter_pkg::CMD_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_cov  <= n_out_cov;
            r_out_rgba <= n_out_rgba;
            r_out_last <= n_out_last;
            r_out_idle <= n_out_idle;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_covered    = r_out_cov;
    assign o_pixel_rgba = r_out_rgba;
    assign o_last_pixel = r_out_last;
    assign o_idle       = r_out_idle;

endmodule

`default_nettype wire

@@ design/ter_setup.sv @@
// Triangle setup pipeline: edge coefficients, clamped bounding box,
// orientation products and edge values at the box corner. Uses ter_pkg.
`default_nettype none

module ter_setup #(
    parameter int MAX_DIM = ter_pkg::MAX_DIM_DEF,
    localparam int CW = $clog2(MAX_DIM),
    localparam int DW = ((CW > ter_pkg::VERT_W - 1) ? CW : ter_pkg::VERT_W - 1) + 2,
    localparam int PW = ter_pkg::DIFF_W + DW
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en2,
    input  wire logic                                i_en3,
    input  wire ter_pkg::t_tri                       i_tri,
    input  wire logic [ter_pkg::RGBA_W-1:0]          i_rgba,
    input  wire logic signed [CW:0]                  i_wm1,
    input  wire logic signed [CW:0]                  i_hm1,
    output logic signed [2*ter_pkg::DIFF_W-1:0]      o_ori_p,
    output logic signed [2*ter_pkg::DIFF_W-1:0]      o_ori_n,
    output logic signed [PW-1:0]                     o_prod_a [3],
    output logic signed [PW-1:0]                     o_prod_b [3],
    output logic signed [ter_pkg::DIFF_W-1:0]        o_coef_a [3],
    output logic signed [ter_pkg::DIFF_W-1:0]        o_coef_b [3],
    output logic [CW-1:0]                            o_lo_x,
    output logic [CW-1:0]                            o_lo_y,
    output logic [CW-1:0]                            o_hi_x,
    output logic [CW-1:0]                            o_hi_y,
    output logic                                     o_empty,
    output logic [ter_pkg::RGBA_W-1:0]               o_rgba
);

    localparam int LW = (CW > ter_pkg::VERT_W) ? CW : ter_pkg::VERT_W;
    localparam int XW = ((CW + 1 > ter_pkg::VERT_W) ? CW + 1 : ter_pkg::VERT_W) + 1;
    localparam int OW = 2 * ter_pkg::DIFF_W;

    function automatic logic signed [ter_pkg::VERT_W-1:0] f_min3(
        input logic signed [ter_pkg::VERT_W-1:0] a,
        input logic signed [ter_pkg::VERT_W-1:0] b,
        input logic signed [ter_pkg::VERT_W-1:0] c
    );
        logic signed [ter_pkg::VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [ter_pkg::VERT_W-1:0] f_max3(
        input logic signed [ter_pkg::VERT_W-1:0] a,
        input logic signed [ter_pkg::VERT_W-1:0] b,
        input logic signed [ter_pkg::VERT_W-1:0] c
    );
        logic signed [ter_pkg::VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Edge endpoints: AB, BC, CA
    logic signed [ter_pkg::VERT_W-1:0] px [3];
    logic signed [ter_pkg::VERT_W-1:0] py [3];
    logic signed [ter_pkg::VERT_W-1:0] qx [3];
    logic signed [ter_pkg::VERT_W-1:0] qy [3];

    assign px[0] = i_tri.a.x;  assign py[0] = i_tri.a.y;
    assign qx[0] = i_tri.b.x;  assign qy[0] = i_tri.b.y;
    assign px[1] = i_tri.b.x;  assign py[1] = i_tri.b.y;
    assign qx[1] = i_tri.c.x;  assign qy[1] = i_tri.c.y;
    assign px[2] = i_tri.c.x;  assign py[2] = i_tri.c.y;
    assign qx[2] = i_tri.a.x;  assign qy[2] = i_tri.a.y;

    // Stage 2 combinational: coefficients and clamped box
    logic signed [ter_pkg::DIFF_W-1:0] n_ea [3];
    logic signed [ter_pkg::DIFF_W-1:0] n_eb [3];
    logic signed [ter_pkg::VERT_W-1:0] mn_x, mn_y, mx_x, mx_y;
    logic [LW-1:0]                     lo_x, lo_y;
    logic signed [XW-1:0]              hi_x, hi_y, lo_xe, lo_ye, mx_xe, mx_ye, w_e, h_e;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ea[k] = ter_pkg::DIFF_W'(qx[k]) - ter_pkg::DIFF_W'(px[k]);
            n_eb[k] = ter_pkg::DIFF_W'(qy[k]) - ter_pkg::DIFF_W'(py[k]);
        end
        mn_x = f_min3(i_tri.a.x, i_tri.b.x, i_tri.c.x);
        mn_y = f_min3(i_tri.a.y, i_tri.b.y, i_tri.c.y);
        mx_x = f_max3(i_tri.a.x, i_tri.b.x, i_tri.c.x);
        mx_y = f_max3(i_tri.a.y, i_tri.b.y, i_tri.c.y);
        lo_x = mn_x[ter_pkg::VERT_W-1] ? '0 : LW'($unsigned(mn_x));
        lo_y = mn_y[ter_pkg::VERT_W-1] ? '0 : LW'($unsigned(mn_y));
        mx_xe = XW'(mx_x);
        mx_ye = XW'(mx_y);
        w_e   = XW'(i_wm1);
        h_e   = XW'(i_hm1);
        hi_x  = (mx_xe < w_e) ? mx_xe : w_e;
        hi_y  = (mx_ye < h_e) ? mx_ye : h_e;
        lo_xe = XW'($signed({1'b0, lo_x}));
        lo_ye = XW'($signed({1'b0, lo_y}));
    end

    // Stage 2 registers
    logic signed [ter_pkg::DIFF_W-1:0] r2_ea [3];
    logic signed [ter_pkg::DIFF_W-1:0] r2_eb [3];
    logic signed [ter_pkg::VERT_W-1:0] r2_px [3];
    logic signed [ter_pkg::VERT_W-1:0] r2_py [3];
    logic [LW-1:0]                     r2_lo_x, r2_lo_y;
    logic [CW-1:0]                     r2_hi_x, r2_hi_y;
    logic                              r2_empty;
    logic [ter_pkg::RGBA_W-1:0]        r2_rgba;

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            for (int k = 0; k < 3; k++) begin
                r2_ea[k] <= n_ea[k];
                r2_eb[k] <= n_eb[k];
                r2_px[k] <= px[k];
                r2_py[k] <= py[k];
            end
            r2_lo_x  <= lo_x;
            r2_lo_y  <= lo_y;
            r2_hi_x  <= hi_x[CW-1:0];
            r2_hi_y  <= hi_y[CW-1:0];
            r2_empty <= (lo_xe > hi_x) || (lo_ye > hi_y);
            r2_rgba  <= i_rgba;
        end
    end

    // Stage 3 combinational: one product per multiplier, all in parallel
    logic signed [DW-1:0] dx [3];
    logic signed [DW-1:0] dy [3];
    logic signed [PW-1:0] n_pa [3];
    logic signed [PW-1:0] n_pb [3];
    logic signed [OW-1:0] n_ori_p, n_ori_n;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx[k]   = DW'($signed({1'b0, r2_lo_x[CW-1:0]})) - DW'(r2_py[k] * 0 + r2_px[k]);
            dy[k]   = DW'($signed({1'b0, r2_lo_y[CW-1:0]})) - DW'(r2_py[k]);
            n_pa[k] = PW'(r2_ea[k]) * PW'(dy[k]);
            n_pb[k] = PW'(r2_eb[k]) * PW'(dx[k]);
        end
        // orientation = ABy*CAx - ABx*CAy
        n_ori_p = OW'(r2_eb[0]) * OW'(r2_ea[2]);
        n_ori_n = OW'(r2_ea[0]) * OW'(r2_eb[2]);
    end

    // Stage 3 registers
    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            for (int k = 0; k < 3; k++) begin
                o_prod_a[k] <= n_pa[k];
                o_prod_b[k] <= n_pb[k];
                o_coef_a[k] <= r2_ea[k];
                o_coef_b[k] <= r2_eb[k];
            end
            o_ori_p <= n_ori_p;
            o_ori_n <= n_ori_n;
            o_lo_x  <= r2_lo_x[CW-1:0];
            o_lo_y  <= r2_lo_y[CW-1:0];
            o_hi_x  <= r2_hi_x;
            o_hi_y  <= r2_hi_y;
            o_empty <= r2_empty;
            o_rgba  <= r2_rgba;
        end
    end

endmodule

`default_nettype wire

@@ design/ter_checker.sv @@
// Port-level checker for the triangle edge rasterizer, bound to the top.
// Depends on ter_pkg and triangle_edge_rasterizer_top_assert.svh.
`default_nettype none

`include "triangle_edge_rasterizer_top_assert.svh"

module ter_checker #(
    parameter int MAX_DIM = ter_pkg::MAX_DIM_DEF,
    localparam int CW = $clog2(MAX_DIM)
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [CW-1:0]              o_pixel_x,
    input wire logic [CW-1:0]              o_pixel_y,
    input wire logic                       o_covered,
    input wire logic [ter_pkg::RGBA_W-1:0] o_pixel_rgba,
    input wire logic                       o_last_pixel,
    input wire logic                       o_idle
);

    // an idle result carries nothing else
    `TER_ASSERT_IMP(a_idle_zero, i_clk, i_rst_n, o_out_valid && o_idle, o_pixel_x == '0 && o_pixel_y == '0 && !o_covered && o_pixel_rgba == '0 && !o_last_pixel, "idle result has nonzero fields")

    // input backpressure only arises from a held result
    `TER_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked result")

    // a stalled result holds
    `TER_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_covered) && $stable(o_pixel_rgba) && $stable(o_idle), "stalled result changed")

endmodule

bind triangle_edge_rasterizer_top ter_checker #(
    .MAX_DIM (MAX_DIM)
) u_ter_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_covered    (o_covered),
    .o_pixel_rgba (o_pixel_rgba),
    .o_last_pixel (o_last_pixel),
    .o_idle       (o_idle)
);

`default_nettype wire

@@ tb/triangle_edge_rasterizer_top_tb.sv @@
// Self-checking testbench for triangle_edge_rasterizer_top: a directed table, then random
// triangle loads and pixel scans under random idling, checked by an edge-function predictor.
// Depends on ter_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module triangle_edge_rasterizer_top_tb;
    import ter_pkg::*;

    // One input item as driven on the ports
    typedef struct packed {
        logic              cmd;
        t_tri              verts;
        logic [RGBA_W-1:0] rgba;
    } tri_item_t;

    // One result item as expected on the ports
    typedef struct packed {
        logic [10:0]       px;
        logic [10:0]       py;
        logic              cov;
        logic [RGBA_W-1:0] rgba;
        logic              last;
        logic              idle;
    } pixel_t;

    // Directed row: the item, and an idle result typed in where it is obvious
    typedef struct packed {
        tri_item_t it;
        logic      typed;
        pixel_t    want;
    } dir_row_t;

    localparam int PHASES     = 9;
    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_LIMIT = 4000;
    localparam int SETTLE      = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_STEP;
    logic signed [VERT_W-1:0] ax = '0, ay = '0, bx = '0, by = '0, cx = '0, cy = '0;
    logic [RGBA_W-1:0]        fill = '0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [10:0]       pix_x, pix_y;
    logic              pix_cov, pix_last, pix_idle;
    logic [RGBA_W-1:0] pix_rgba;

    // Predictor state
    int              vtx[6];
    bit              wind_pos;
    bit              scanning;
    int              scan_col, scan_row;
    int              box_lo_x, box_hi_x, box_hi_y;
    logic [RGBA_W-1:0] rgba_q;
    logic [CFG_W-1:0]  img_w = IMG_SIZE_RST;
    logic [CFG_W-1:0]  img_h = IMG_SIZE_RST;

    pixel_t   pending_pixels[$];
    dir_row_t dir_rows[$];
    int       err_count = 0;
    int       n_sent = 0;
    bit       calm = 1'b0;

    triangle_edge_rasterizer_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_command    (cmd),
        .i_vert_a_x   (ax),
        .i_vert_a_y   (ay),
        .i_vert_b_x   (bx),
        .i_vert_b_y   (by),
        .i_vert_c_x   (cx),
        .i_vert_c_y   (cy),
        .i_fill_rgba  (fill),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pixel_x    (pix_x),
        .o_pixel_y    (pix_y),
        .o_covered    (pix_cov),
        .o_pixel_rgba (pix_rgba),
        .o_last_pixel (pix_last),
        .o_idle       (pix_idle)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int sat_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
    endfunction

    function automatic int min3(input int a, input int b, input int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Edge function of P->Q evaluated at (x, y)
    function automatic longint edge_val(input int px, input int py, input int qx, input int qy,
                                        input int x, input int y);
        return longint'(qx - px) * longint'(y - py) - longint'(qy - py) * longint'(x - px);
    endfunction

    // Advance the predicted rasterizer by one item; returns 1 when a pixel comes out
    function automatic bit rasterize(input tri_item_t it, output pixel_t px);
        longint orient, e_ab, e_bc, e_ca;
        int     w, h, lo_x, hi_x, lo_y, hi_y;
        bit     at_end;
        px = '0;
        if (it.cmd == CMD_LOAD) begin
            vtx[0] = int'($signed(it.verts.a.x));
            vtx[1] = int'($signed(it.verts.a.y));
            vtx[2] = int'($signed(it.verts.b.x));
            vtx[3] = int'($signed(it.verts.b.y));
            vtx[4] = int'($signed(it.verts.c.x));
            vtx[5] = int'($signed(it.verts.c.y));
            rgba_q   = it.rgba;
            scanning = 1'b0;
            orient   = edge_val(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
            wind_pos = orient > 0;
            if (orient == 0)
                return 1'b0;
            w    = sat_dim(img_w);
            h    = sat_dim(img_h);
            lo_x = min3(vtx[0], vtx[2], vtx[4]);
            hi_x = max3(vtx[0], vtx[2], vtx[4]);
            lo_y = min3(vtx[1], vtx[3], vtx[5]);
            hi_y = max3(vtx[1], vtx[3], vtx[5]);
            if (lo_x < 0) lo_x = 0;
            if (lo_y < 0) lo_y = 0;
            if (hi_x > w - 1) hi_x = w - 1;
            if (hi_y > h - 1) hi_y = h - 1;
            if (lo_x > hi_x || lo_y > hi_y)
                return 1'b0;
            box_lo_x = lo_x;
            box_hi_x = hi_x;
            box_hi_y = hi_y;
            scan_col = lo_x;
            scan_row = lo_y;
            scanning = 1'b1;
            return 1'b0;
        end
        if (!scanning) begin
            px.idle = 1'b1;
            return 1'b1;
        end
        e_ab = edge_val(vtx[0], vtx[1], vtx[2], vtx[3], scan_col, scan_row);
        e_bc = edge_val(vtx[2], vtx[3], vtx[4], vtx[5], scan_col, scan_row);
        e_ca = edge_val(vtx[4], vtx[5], vtx[0], vtx[1], scan_col, scan_row);
        at_end = (scan_col == box_hi_x) && (scan_row == box_hi_y);
        if (wind_pos)
            px.cov = (e_ab >= 0) && (e_bc >= 0) && (e_ca >= 0);
        else
            px.cov = (e_ab <= 0) && (e_bc <= 0) && (e_ca <= 0);
        px.px   = 11'(scan_col);
        px.py   = 11'(scan_row);
        px.rgba = rgba_q;
        px.last = at_end;
        // row-major walk over the box
        if (at_end) begin
            scanning = 1'b0;
        end else if (scan_col == box_hi_x) begin
            scan_col = box_lo_x;
            scan_row++;
        end else begin
            scan_col++;
        end
        return 1'b1;
    endfunction

    // Present one item, wait for it to be taken, then maybe idle a while
    task automatic send_item(input tri_item_t it, input bit typed, input pixel_t want);
        pixel_t px;
        bit     has_px;
        in_valid <= 1'b1;
        cmd      <= it.cmd;
        ax       <= it.verts.a.x;
        ay       <= it.verts.a.y;
        bx       <= it.verts.b.x;
        by       <= it.verts.b.y;
        cx       <= it.verts.c.x;
        cy       <= it.verts.c.y;
        fill     <= it.rgba;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        has_px = rasterize(it, px);
        if (has_px)
            pending_pixels.push_back(typed ? want : px);
        n_sent++;
        if (!calm && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 28);
        end
    endtask

    // Let every expected pixel arrive, then let the pipeline settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        if (pending_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then the bus goes idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << REG_SEL_BIT;
        pwdata  <= {(APB_DW - CFG_W)'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            img_w = val;
        else
            img_h = val;
        @(posedge clk);
    endtask

    function automatic tri_item_t make_tri(input logic c, input int x0, input int y0,
                                           input int x1, input int y1, input int x2,
                                           input int y2, input logic [RGBA_W-1:0] rgba);
        tri_item_t it;
        it.cmd       = c;
        it.verts.a.x = VERT_W'(x0);
        it.verts.a.y = VERT_W'(y0);
        it.verts.b.x = VERT_W'(x1);
        it.verts.b.y = VERT_W'(y1);
        it.verts.c.x = VERT_W'(x2);
        it.verts.c.y = VERT_W'(y2);
        it.rgba      = rgba;
        return it;
    endfunction

    function automatic dir_row_t dir_row(input logic c, input int x0, input int y0,
                                         input int x1, input int y1, input int x2,
                                         input int y2, input logic [RGBA_W-1:0] rgba,
                                         input bit typed);
        dir_row_t r;
        r.it        = make_tri(c, x0, y0, x1, y1, x2, y2, rgba);
        r.typed     = typed;
        r.want      = '0;
        r.want.idle = typed;
        return r;
    endfunction

    // Step items carry random, unused vertex and color bits
    function automatic tri_item_t rand_step();
        return make_tri(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
    endfunction

    function automatic int clip_coord(input int v);
        return (v < -4096) ? -4096 : ((v > 4095) ? 4095 : v);
    endfunction

    // Random load: mostly small triangles around the image, plus degenerate,
    // full-range and far-corner shapes
    function automatic tri_item_t rand_load();
        int kind, w, h, ox, oy, ext, dx, dy, k;
        w    = sat_dim(img_w);
        h    = sat_dim(img_h);
        kind = $urandom_range(99);
        if (kind < 65) begin
            ext = ($urandom_range(9) == 0) ? 24 : 6;
            ox  = int'($urandom_range(w + 12)) - 8;
            oy  = int'($urandom_range(h + 12)) - 8;
            return make_tri(CMD_LOAD, clip_coord(ox + $urandom_range(ext)),
                            clip_coord(oy + $urandom_range(ext)),
                            clip_coord(ox + $urandom_range(ext)),
                            clip_coord(oy + $urandom_range(ext)),
                            clip_coord(ox + $urandom_range(ext)),
                            clip_coord(oy + $urandom_range(ext)), $urandom);
        end else if (kind < 75) begin
            // collinear or coincident points
            ox = int'($urandom_range(320)) - 20;
            oy = int'($urandom_range(320)) - 20;
            dx = int'($urandom_range(16)) - 8;
            dy = int'($urandom_range(16)) - 8;
            k  = $urandom_range(2);
            return make_tri(CMD_LOAD, ox, oy, ox + dx, oy + dy, ox + k * dx, oy + k * dy,
                            $urandom);
        end else if (kind < 85) begin
            return make_tri(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        end
        // straddles the far corner of the image
        ext = $urandom_range(40);
        ox  = w - int'($urandom_range(20));
        oy  = h - int'($urandom_range(20));
        return make_tri(CMD_LOAD, clip_coord(ox + $urandom_range(ext)),
                        clip_coord(oy + $urandom_range(ext)),
                        clip_coord(ox - $urandom_range(ext)),
                        clip_coord(oy + $urandom_range(ext)),
                        clip_coord(ox + $urandom_range(ext)),
                        clip_coord(oy - $urandom_range(ext)), $urandom);
    endfunction

    // Load one triangle, then step through its box (sometimes cut short)
    task automatic run_triangle();
        int n_pix, n_steps;
        send_item(rand_load(), 1'b0, '0);
        n_pix = scanning ? (box_hi_x - box_lo_x + 1) * (box_hi_y - scan_row + 1) : 0;
        if ($urandom_range(9) == 0)
            n_steps = $urandom_range(n_pix);
        else
            n_steps = n_pix + $urandom_range(2);
        if (n_steps > 120)
            n_steps = $urandom_range(1, 40);
        repeat (n_steps) send_item(rand_step(), 1'b0, '0);
    endtask

    // Result check and receiver stall
    always @(posedge clk) begin : pixel_check
        pixel_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d idle=%0b",
                                          pix_x, pix_y, pix_idle));
            end else begin
                want = pending_pixels.pop_front();
                if (pix_x !== want.px)
                    report_mismatch($sformatf("pixel_x %0d, want %0d", pix_x, want.px));
                if (pix_y !== want.py)
                    report_mismatch($sformatf("pixel_y %0d, want %0d", pix_y, want.py));
                if (pix_cov !== want.cov)
                    report_mismatch($sformatf("covered %0b, want %0b at (%0d,%0d)",
                                              pix_cov, want.cov, want.px, want.py));
                if (pix_rgba !== want.rgba)
                    report_mismatch($sformatf("pixel_rgba %h, want %h", pix_rgba,
                                              want.rgba));
                if (pix_last !== want.last)
                    report_mismatch($sformatf("last_pixel %0b, want %0b at (%0d,%0d)",
                                              pix_last, want.last, want.px, want.py));
                if (pix_idle !== want.idle)
                    report_mismatch($sformatf("idle %0b, want %0b", pix_idle, want.idle));
            end
        end
        out_stall <= !calm && ($urandom_range(99) < 28);
    end

    // Main sequence
    initial begin : stimulus
        int cfg_w[PHASES];
        int cfg_h[PHASES];
        int start;

        // Directed table at the reset image size of 256 x 256
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        dir_rows.push_back(dir_row(CMD_LOAD, 4095, 4095, 4095, 4095, 4095, 4095,
                                   32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        dir_rows.push_back(dir_row(CMD_LOAD, -4096, -4096, 0, 0, 4095, 4095,
                                   32'h0F0F_0F0F, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        // nondegenerate but wholly left of and above the image
        dir_rows.push_back(dir_row(CMD_LOAD, -4096, -4096, -1, -4096, -4096, -1,
                                   32'h1111_2222, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        // wholly right of the image
        dir_rows.push_back(dir_row(CMD_LOAD, 256, 0, 4095, 0, 256, 4095,
                                   32'h3333_4444, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        // counterclockwise 2x2 box, scanned to the end, then idle
        dir_rows.push_back(dir_row(CMD_LOAD, 10, 10, 11, 10, 10, 11, 32'h1234_5678, 1'b0));
        repeat (4) dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
        // clockwise 2x2 box, cut short by a full-range load
        dir_rows.push_back(dir_row(CMD_LOAD, 10, 10, 10, 11, 11, 10, 32'hFFFF_FFFF, 1'b0));
        repeat (2) dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b0));
        dir_rows.push_back(dir_row(CMD_LOAD, -4096, -4096, 4095, -4096, -4096, 4095,
                                   32'h0, 1'b0));
        repeat (3) dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b0));
        // a degenerate load drops the active triangle
        dir_rows.push_back(dir_row(CMD_LOAD, 0, 0, 0, 0, 0, 0, 32'hA5A5_A5A5, 1'b0));
        dir_rows.push_back(dir_row(CMD_STEP, 0, 0, 0, 0, 0, 0, 32'h0, 1'b1));

        // Image sizes per random phase: unit, maximum, saturating, zero, odd shapes
        cfg_w = '{1, 2048, 4095, 0, 19, 2047, 5, 0, 16};
        cfg_h = '{1, 2048, 4095, 37, 0, 3, 2049, 0, 16};
        cfg_w[7] = $urandom_range(1, 300);
        cfg_h[7] = $urandom_range(1, 300);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_IMAGE_WIDTH, CFG_W'(cfg_w[p]));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(cfg_h[p]));
            calm  = (p == 2);
            start = n_sent;
            while (n_sent - start < PHASE_ITEMS)
                run_triangle();
            wait_drained();
        end

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
